[design/wcm_pkg.sv]
// Shared types and constants of the window coverage median unit.
package wcm_pkg;

  localparam int unsigned PosW    = 32;
  localparam int unsigned LenW    = 11;
  localparam int unsigned MedW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;

  localparam logic [CfgIdxW-1:0] RegLeftStart  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLeftLen    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRightStart = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRightLen   = 3'd3;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_ADD,
    OP_COUNT
  } dp_op_e;

  typedef struct packed {
    logic   start;
    dp_op_e op;
    logic   win;
    logic   med_init;
    logic   store;
    logic   load_read;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic srch_done;
  } dp_status_t;

endpackage

[design/wcm_in_if.sv]
// Read channel interface.
interface wcm_in_if;
  logic                        valid;
  logic                        ready;
  logic [wcm_pkg::PosW-1:0]    read_start;
  logic [wcm_pkg::PosW-1:0]    read_end;
  logic                        last_read;
  modport source (output valid, read_start, read_end, last_read, input ready);
  modport sink   (input valid, read_start, read_end, last_read, output ready);
endinterface

[design/wcm_out_if.sv]
// Result channel interface.
interface wcm_out_if;
  logic                        valid;
  logic                        ready;
  logic [wcm_pkg::MedW-1:0]    left_median;
  logic [wcm_pkg::MedW-1:0]    right_median;
  modport source (output valid, left_median, right_median, input ready);
  modport sink   (input valid, left_median, right_median, output ready);
endinterface

[design/wcm_cfg_if.sv]
// Configuration write channel interface.
interface wcm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wcm_pkg::CfgIdxW-1:0]   index;
  logic [wcm_pkg::CfgDatW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/window_coverage_median_unit.sv]
// Top level of the window coverage median unit.
//
//  channel | dir | word                                    | accepted when
//  in_i    | in  | read_start, read_end, last_read         | valid && ready
//  out_o   | out | left_median, right_median               | valid && ready
//  cfg_i   | in  | index, data                             | valid && ready (ready is 1)
//
// Each read is taken through a read-modify-write walk over its overlap with each window
// in that window's depth RAM, with no walk for a window that it misses; no new read is
// taken until both walks are done.
// A last read adds, per window, a setup step and up to DEPTH_BITS + 1 counting
// passes, each a walk over the window's clamped length.
// After reset and after each result, a clearing pass over all WINDOW_DEPTH entries
// zeroes both RAMs while no read is taken. The result waits in an output register,
// and a stalled result only holds back the next last read, at its hand-off.
module window_coverage_median_unit #(
  parameter int unsigned WINDOW_DEPTH = 1024,
  parameter int unsigned DEPTH_BITS   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wcm_in_if.sink     in_i,
  wcm_out_if.source  out_o,
  wcm_cfg_if.sink    cfg_i
);
  wcm_pkg::dp_cmd_t    cmd;
  wcm_pkg::dp_status_t sts;

  assign cfg_i.ready = 1'b1;

  wcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last_read),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  wcm_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH), .DEPTH_BITS(DEPTH_BITS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .read_start_i   (in_i.read_start),
    .read_end_i     (in_i.read_end),
    .cfg_we_i       (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .left_median_o  (out_o.left_median),
    .right_median_o (out_o.right_median)
  );
endmodule

[design/wcm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module wcm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

[design/wcm_ctrl.sv]
// Sequencer for read updates, median search passes, result hand-off and clearing.
module wcm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wcm_pkg::dp_cmd_t    cmd_o,
  input  wcm_pkg::dp_status_t sts_i
);
  typedef enum logic [3:0] {
    S_CLR_GO, S_CLR_WAIT, S_IDLE, S_ADD_GO, S_ADD_WAIT,
    S_MED_INIT, S_CNT_GO, S_CNT_WAIT, S_OUT
  } state_e;

  state_e state_q;
  logic   win_q;
  logic   last_q;
  logic   out_valid_q;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o = '0;
    cmd_o.op  = wcm_pkg::OP_CLEAR;
    cmd_o.win = win_q;
    unique case (state_q)
      S_CLR_GO: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = wcm_pkg::OP_CLEAR;
      end
      S_IDLE: begin
        cmd_o.load_read = in_valid_i;
      end
      S_ADD_GO: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = wcm_pkg::OP_ADD;
      end
      S_MED_INIT: begin
        cmd_o.med_init = 1'b1;
      end
      S_CNT_GO: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = wcm_pkg::OP_COUNT;
      end
      S_CNT_WAIT: begin
        cmd_o.store = !sts_i.busy && sts_i.srch_done;
      end
      S_OUT: begin
        cmd_o.load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR_GO;
      win_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR_GO:   state_q <= S_CLR_WAIT;
        S_CLR_WAIT: begin
          if (!sts_i.busy) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            last_q  <= in_last_i;
            win_q   <= 1'b0;
            state_q <= S_ADD_GO;
          end
        end
        S_ADD_GO:   state_q <= S_ADD_WAIT;
        S_ADD_WAIT: begin
          if (!sts_i.busy) begin
            if (!win_q) begin
              win_q   <= 1'b1;
              state_q <= S_ADD_GO;
            end else if (last_q) begin
              win_q   <= 1'b0;
              state_q <= S_MED_INIT;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_MED_INIT: state_q <= S_CNT_GO;
        S_CNT_GO:   state_q <= S_CNT_WAIT;
        S_CNT_WAIT: begin
          if (!sts_i.busy) begin
            if (!sts_i.srch_done) begin
              state_q <= S_CNT_GO;
            end else if (!win_q) begin
              win_q   <= 1'b1;
              state_q <= S_MED_INIT;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_free) state_q <= S_CLR_GO;
        end
        default: state_q <= S_CLR_GO;
      endcase
    end
  end
endmodule

[design/wcm_datapath.sv]
// Depth stores, address walker, counting pass and median search registers.
module wcm_datapath #(
  parameter int unsigned WINDOW_DEPTH = 1024,
  parameter int unsigned DEPTH_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wcm_pkg::dp_cmd_t              cmd_i,
  output wcm_pkg::dp_status_t           sts_o,
  input  logic [wcm_pkg::PosW-1:0]      read_start_i,
  input  logic [wcm_pkg::PosW-1:0]      read_end_i,
  input  logic                          cfg_we_i,
  input  logic [wcm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wcm_pkg::CfgDatW-1:0]   cfg_data_i,
  output logic [wcm_pkg::MedW-1:0]      left_median_o,
  output logic [wcm_pkg::MedW-1:0]      right_median_o
);
  localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned DB = DEPTH_BITS;
  localparam logic [DB-1:0] DepthMax = {DB{1'b1}};
  localparam logic [31:0]   WinDepth32 = 32'(WINDOW_DEPTH);

  // Configuration registers.
  logic [wcm_pkg::PosW-1:0] lstart_q, rstart_q;
  logic [wcm_pkg::LenW-1:0] llen_q, rlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lstart_q <= '0;
      rstart_q <= '0;
      llen_q   <= wcm_pkg::LenW'(1);
      rlen_q   <= wcm_pkg::LenW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wcm_pkg::RegLeftStart:  lstart_q <= cfg_data_i;
        wcm_pkg::RegLeftLen:    llen_q   <= cfg_data_i[wcm_pkg::LenW-1:0];
        wcm_pkg::RegRightStart: rstart_q <= cfg_data_i;
        wcm_pkg::RegRightLen:   rlen_q   <= cfg_data_i[wcm_pkg::LenW-1:0];
        default: begin
        end
      endcase
    end
  end

  logic [wcm_pkg::PosW-1:0] rs_q, re_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_read) begin
      rs_q <= read_start_i;
      re_q <= read_end_i;
    end
  end

  // Clamped overlap of the captured read with the selected window.
  logic [wcm_pkg::PosW-1:0] wstart;
  logic [31:0]              len32, n32, b32, e32;
  logic [CW-1:0]            n_w, b_w, e_w;

  always_comb begin
    wstart = cmd_i.win ? rstart_q : lstart_q;
    len32  = 32'(cmd_i.win ? rlen_q : llen_q);
    n32    = (len32 > WinDepth32) ? WinDepth32 : len32;
    b32    = (rs_q >= wstart) ? (rs_q - wstart) : 32'd0;
    e32    = (re_q >= wstart) ? (re_q - wstart) : 32'd0;
    if (b32 > n32) b32 = n32;
    if (e32 > n32) e32 = n32;
    n_w = n32[CW-1:0];
    b_w = b32[CW-1:0];
    e_w = e32[CW-1:0];
  end

  // Walker and one-deep read pipeline.
  wcm_pkg::dp_op_e op_q;
  logic            win_q, run_q, pv_q, plast_q;
  logic [CW-1:0]   pos_q, end_q, cnt_q;
  logic [AW-1:0]   paddr_q;
  logic [CW-1:0]   beg_sel, end_sel;
  logic            start_empty;

  always_comb begin
    unique case (cmd_i.op)
      wcm_pkg::OP_ADD: begin
        beg_sel = b_w;
        end_sel = e_w;
      end
      wcm_pkg::OP_COUNT: begin
        beg_sel = '0;
        end_sel = n_w;
      end
      default: begin
        beg_sel = '0;
        end_sel = CW'(WINDOW_DEPTH);
      end
    endcase
    start_empty = (beg_sel >= end_sel);
  end

  logic [DB-1:0] l_rdata, r_rdata, rdata, inc, wdata, thr;
  logic          l_we, r_we, hit;
  logic [AW-1:0] waddr;

  // Median search registers.
  logic          first_q, zero_q;
  logic [DB-1:0] lo_q, hi_q;
  logic [CW-1:0] rank_q;
  logic [DB:0]   mid_ext;
  logic [DB-1:0] mid;
  logic          upd;
  logic [CW-1:0] upd_cnt;

  assign rdata   = win_q ? r_rdata : l_rdata;
  assign inc     = (rdata == DepthMax) ? rdata : rdata + DB'(1);
  assign mid_ext = {1'b0, lo_q} + (({1'b0, hi_q} - {1'b0, lo_q} + (DB + 1)'(1)) >> 1);
  assign mid     = mid_ext[DB-1:0];
  assign thr     = first_q ? DB'(1) : mid;
  assign hit     = (rdata >= thr);

  always_comb begin
    if (op_q == wcm_pkg::OP_CLEAR) begin
      waddr = pos_q[AW-1:0];
      wdata = '0;
      l_we  = run_q;
      r_we  = run_q;
    end else begin
      waddr = paddr_q;
      wdata = inc;
      l_we  = pv_q && (op_q == wcm_pkg::OP_ADD) && !win_q;
      r_we  = pv_q && (op_q == wcm_pkg::OP_ADD) && win_q;
    end
  end

  // A counting pass ends either at its last drained entry or at once when empty.
  always_comb begin
    upd     = 1'b0;
    upd_cnt = cnt_q + CW'(hit);
    if (cmd_i.start && cmd_i.op == wcm_pkg::OP_COUNT && start_empty) begin
      upd     = 1'b1;
      upd_cnt = '0;
    end else if (pv_q && plast_q && op_q == wcm_pkg::OP_COUNT) begin
      upd = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      pv_q  <= 1'b0;
      op_q  <= wcm_pkg::OP_CLEAR;
      win_q <= 1'b0;
    end else begin
      pv_q <= 1'b0;
      if (cmd_i.start) begin
        op_q  <= cmd_i.op;
        win_q <= cmd_i.win;
        run_q <= !start_empty;
      end else if (run_q) begin
        pv_q <= (op_q != wcm_pkg::OP_CLEAR);
        if (pos_q + CW'(1) == end_q) run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pos_q <= beg_sel;
      end_q <= end_sel;
      cnt_q <= '0;
    end else begin
      if (run_q) begin
        paddr_q <= pos_q[AW-1:0];
        plast_q <= (pos_q + CW'(1) == end_q);
        pos_q   <= pos_q + CW'(1);
      end
      if (pv_q) cnt_q <= upd_cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.med_init) begin
      first_q <= 1'b1;
      zero_q  <= 1'b0;
      lo_q    <= DB'(1);
      hi_q    <= DepthMax;
    end else if (upd) begin
      if (first_q) begin
        first_q <= 1'b0;
        if (upd_cnt == '0) zero_q <= 1'b1;
        rank_q <= upd_cnt >> 1;
      end else if (upd_cnt > rank_q) begin
        lo_q <= mid;
      end else begin
        hi_q <= mid - DB'(1);
      end
    end
  end

  assign sts_o.busy      = run_q || pv_q;
  assign sts_o.srch_done = zero_q || (!first_q && (lo_q >= hi_q));

  logic [31:0]              lo32;
  logic [wcm_pkg::MedW-1:0] med;
  logic [wcm_pkg::MedW-1:0] lmed_q, rmed_q, lout_q, rout_q;

  assign lo32 = 32'(lo_q);
  assign med  = zero_q ? '0 : ((lo32 > 32'h0000_FFFF) ? 16'hFFFF : lo32[15:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      if (cmd_i.win) rmed_q <= med;
      else lmed_q <= med;
    end
    if (cmd_i.load_out) begin
      lout_q <= lmed_q;
      rout_q <= rmed_q;
    end
  end

  assign left_median_o  = lout_q;
  assign right_median_o = rout_q;

  wcm_ram #(.WIDTH(DB), .DEPTH(WINDOW_DEPTH)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (pos_q[AW-1:0]),
    .rdata_o (l_rdata)
  );

  wcm_ram #(.WIDTH(DB), .DEPTH(WINDOW_DEPTH)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (pos_q[AW-1:0]),
    .rdata_o (r_rdata)
  );
endmodule
